// File: hdl/multi_knob_rotary_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// multi knob rotary decoder assertion macros
// shared concurrent assertion forms, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef MULTI_KNOB_ROTARY_DECODER_CORE_DEFINES_SVH
`define MULTI_KNOB_ROTARY_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define MKRD_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define MKRD_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hdl/mkrd_pkg.sv
// ----------------------------------------------------------------------------
// mkrd_pkg
// types and constants shared by the multi knob rotary decoder
// ----------------------------------------------------------------------------
`default_nettype none

package mkrd_pkg;

	localparam int PIN_W        = 8;
	localparam int KNOB_W       = 3;
	localparam int MAX_WIDE     = 4;
	localparam int SLOTS        = MAX_WIDE + 1;
	localparam int NARROW_SLOT  = MAX_WIDE;
	localparam int BIT_A        = 0;
	localparam int BIT_B        = 1;
	localparam logic [PIN_W-1:0] WIDE_MASK   = 8'hFF;
	localparam logic [1:0]       NARROW_MASK = 2'b11;
	localparam logic [1:0]       FILL_FULL   = 2'd2;

	typedef enum logic {
		PORT_WIDE   = 1'b0,
		PORT_NARROW = 1'b1
	} port_t;

	typedef struct packed {
		logic hit;
		logic ccw;
	} lane_res_t;

	typedef struct packed {
		logic             load;
		logic [SLOTS-1:0] mask;
		logic [SLOTS-1:0] ccw;
	} merge_load_t;

endpackage

`default_nettype wire

// File: hdl/mkrd_in_if.sv
// ----------------------------------------------------------------------------
// mkrd_in_if
// snapshot channel: port select and raw pin levels
// ----------------------------------------------------------------------------
`default_nettype none

interface mkrd_in_if;
	logic                       valid;
	logic                       ready;
	logic                       port_select;
	logic [mkrd_pkg::PIN_W-1:0] pin_levels;

	modport source (output valid, output port_select, output pin_levels, input ready);
	modport sink   (input valid, input port_select, input pin_levels, output ready);
endinterface

`default_nettype wire

// File: hdl/mkrd_out_if.sv
// ----------------------------------------------------------------------------
// mkrd_out_if
// report channel: knob, direction and last-report mark
// ----------------------------------------------------------------------------
`default_nettype none

interface mkrd_out_if;
	logic                        valid;
	logic                        ready;
	logic [mkrd_pkg::KNOB_W-1:0] knob_index;
	logic                        counter_clockwise;
	logic                        last_report;

	modport source (output valid, output knob_index, output counter_clockwise,
		output last_report, input ready);
	modport sink   (input valid, input knob_index, input counter_clockwise,
		input last_report, output ready);
endinterface

`default_nettype wire

// File: hdl/mkrd_lane.sv
// ----------------------------------------------------------------------------
// mkrd_lane
// one knob checker: quiet newest pair, then direction from old and oldest
// ----------------------------------------------------------------------------
`default_nettype none

module mkrd_lane (
	input  logic [1:0]          newest,
	input  logic [1:0]          old,
	input  logic [1:0]          oldest,
	output mkrd_pkg::lane_res_t res
);

	logic quiet;
	logic ccw;
	logic cw;

	assign quiet   = (newest == 2'b00);
	assign ccw     = old[mkrd_pkg::BIT_A] && oldest[mkrd_pkg::BIT_B];
	assign cw      = old[mkrd_pkg::BIT_B] && oldest[mkrd_pkg::BIT_A];
	assign res.hit = quiet && (ccw || cw);
	assign res.ccw = ccw;

endmodule

`default_nettype wire

// File: hdl/mkrd_merge.sv
// ----------------------------------------------------------------------------
// mkrd_merge
// holds the lane hits of one word and issues them in knob order
// ----------------------------------------------------------------------------
`default_nettype none

module mkrd_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mkrd_pkg::merge_load_t ld,
	output logic                  free,
	mkrd_out_if.source            report
);

	logic [mkrd_pkg::SLOTS-1:0]  pending_q;
	logic [mkrd_pkg::SLOTS-1:0]  ccw_q;
	logic [mkrd_pkg::SLOTS-1:0]  low;
	logic [mkrd_pkg::KNOB_W-1:0] sel;
	logic                        found;
	logic                        take;
	logic                        last;

	always_comb begin
		low   = '0;
		sel   = '0;
		found = 1'b0;
		for (int i = 0; i < mkrd_pkg::SLOTS; i++) begin
			if (pending_q[i] && !found) begin
				low[i] = 1'b1;
				sel    = mkrd_pkg::KNOB_W'(i);
				found  = 1'b1;
			end
		end
	end

	assign last  = ((pending_q & ~low) == '0);
	assign take  = report.valid && report.ready;
	assign free  = (pending_q == '0) || (take && last);

	assign report.valid             = (pending_q != '0);
	assign report.knob_index        = sel;
	assign report.counter_clockwise = |(ccw_q & low);
	assign report.last_report       = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (ld.load) begin
			pending_q <= ld.mask;
		end else if (take) begin
			pending_q <= pending_q & ~low;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			ccw_q <= ld.ccw;
		end
	end

endmodule

`default_nettype wire

// File: hdl/multi_knob_rotary_decoder_core.sv
// ----------------------------------------------------------------------------
// multi_knob_rotary_decoder_core
// quadrature decoder for a four-knob wide port and a one-knob narrow port
// ----------------------------------------------------------------------------
// Each word on sample is an active-low pin snapshot from one port. It is
// inverted, masked and added to that port's three-deep window; once the window
// is full, one checker lane per knob looks for a completed step and the
// results are issued on report in ascending knob order, one per cycle while
// report.ready is high, with last_report on the final one. A snapshot that
// gives no report leaves sample.ready high, so snapshots may follow back to
// back; a snapshot that gives reports, at most four, holds sample.ready low
// until its last report is taken, and the next snapshot is taken in the cycle
// its last report is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_knob_rotary_decoder_core #(
	parameter int WIDE_PORT_KNOBS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	mkrd_in_if.sink    sample,
	mkrd_out_if.source report
);

	localparam int LANES = (WIDE_PORT_KNOBS < mkrd_pkg::MAX_WIDE) ?
		WIDE_PORT_KNOBS : mkrd_pkg::MAX_WIDE;

	logic [mkrd_pkg::PIN_W-1:0] wide_win_q [2];
	logic [1:0]                 wide_fill_q;
	logic [1:0]                 narrow_win_q [2];
	logic [1:0]                 narrow_fill_q;

	logic                       narrow;
	logic                       accept;
	logic                       full;
	logic                       free;
	logic [mkrd_pkg::PIN_W-1:0] snap;
	logic [mkrd_pkg::PIN_W-1:0] old;
	logic [mkrd_pkg::PIN_W-1:0] oldest;
	logic [mkrd_pkg::SLOTS-1:0] hits;
	logic [mkrd_pkg::SLOTS-1:0] dirs;
	mkrd_pkg::lane_res_t        lane_res [mkrd_pkg::MAX_WIDE];
	mkrd_pkg::merge_load_t      ld;

	assign narrow = (mkrd_pkg::port_t'(sample.port_select) == mkrd_pkg::PORT_NARROW);
	assign accept = sample.valid && sample.ready;
	assign sample.ready = free;

	always_comb begin
		if (narrow) begin
			snap   = {6'b0, ~sample.pin_levels[1:0] & mkrd_pkg::NARROW_MASK};
			old    = {6'b0, narrow_win_q[1]};
			oldest = {6'b0, narrow_win_q[0]};
			full   = (narrow_fill_q == mkrd_pkg::FILL_FULL);
		end else begin
			snap   = ~sample.pin_levels & mkrd_pkg::WIDE_MASK;
			old    = wide_win_q[1];
			oldest = wide_win_q[0];
			full   = (wide_fill_q == mkrd_pkg::FILL_FULL);
		end
	end

	for (genvar g = 0; g < mkrd_pkg::MAX_WIDE; g++) begin : g_lane
		mkrd_lane u_lane (
			.newest (snap[2*g+1:2*g]),
			.old    (old[2*g+1:2*g]),
			.oldest (oldest[2*g+1:2*g]),
			.res    (lane_res[g])
		);
	end

	always_comb begin
		hits = '0;
		dirs = '0;
		for (int i = 0; i < mkrd_pkg::MAX_WIDE; i++) begin
			hits[i] = full && !narrow && (i < LANES) && lane_res[i].hit;
			dirs[i] = lane_res[i].ccw;
		end
		hits[mkrd_pkg::NARROW_SLOT] = full && narrow && lane_res[0].hit;
		dirs[mkrd_pkg::NARROW_SLOT] = lane_res[0].ccw;
	end

	assign ld.load = accept && (hits != '0);
	assign ld.mask = hits;
	assign ld.ccw  = dirs;

	// window update per snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_win_q[0]   <= '0;
			wide_win_q[1]   <= '0;
			wide_fill_q     <= '0;
			narrow_win_q[0] <= '0;
			narrow_win_q[1] <= '0;
			narrow_fill_q   <= '0;
		end else if (accept) begin
			if (narrow) begin
				if (!full) begin
					narrow_win_q[narrow_fill_q[0]] <= snap[1:0];
					narrow_fill_q                  <= narrow_fill_q + 2'd1;
				end else if (hits != '0) begin
					narrow_win_q[0] <= '0;
					narrow_win_q[1] <= '0;
					narrow_fill_q   <= '0;
				end else begin
					narrow_win_q[0] <= narrow_win_q[1];
					narrow_win_q[1] <= snap[1:0];
				end
			end else begin
				if (!full) begin
					wide_win_q[wide_fill_q[0]] <= snap;
					wide_fill_q                <= wide_fill_q + 2'd1;
				end else if (hits != '0) begin
					wide_win_q[0] <= '0;
					wide_win_q[1] <= '0;
					wide_fill_q   <= '0;
				end else begin
					wide_win_q[0] <= wide_win_q[1];
					wide_win_q[1] <= snap;
				end
			end
		end
	end

	mkrd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.free   (free),
		.report (report)
	);

endmodule

`default_nettype wire

// File: hdl/mkrd_checker.sv
// ----------------------------------------------------------------------------
// mkrd_checker
// port-level checks for the rotary decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_knob_rotary_decoder_core_defines.svh"

module mkrd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mkrd_pkg::KNOB_W-1:0] knob_index,
	input logic                        counter_clockwise,
	input logic                        last_report
);

	`MKRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(knob_index) && $stable(counter_clockwise) && $stable(last_report), "report changed while stalled")

	`MKRD_ASSERT_NOW(a_knob_range, out_valid, knob_index <= 3'd4, "knob index out of range")

	`MKRD_ASSERT_NOW(a_ready_gap, in_ready && out_valid, out_ready && last_report, "snapshot taken while reports remain")

	`MKRD_ASSERT_NEXT(a_more_follow, out_valid && out_ready && !last_report, out_valid && (knob_index > $past(knob_index)), "report sequence broken")

endmodule

bind multi_knob_rotary_decoder_core mkrd_checker u_mkrd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_ready          (sample.ready),
	.out_valid         (report.valid),
	.out_ready         (report.ready),
	.knob_index        (report.knob_index),
	.counter_clockwise (report.counter_clockwise),
	.last_report       (report.last_report)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi knob rotary decoder core
// ----------------------------------------------------------------------------
// Pin snapshots go in on the sample channel and knob step reports come back
// on the report channel. A behavioral decoder inside the bench keeps its own
// three-deep window per port and predicts each report: knob, direction and
// last mark. The directed table walks fills after reset, both directions on
// both ports, ignored high pins on the narrow port, all four wide knobs at
// once and windows that slide without a report. The random part sends mostly
// three-snapshot turn sequences with random content plus some loose
// snapshots. Both channels idle at random, with stretches of no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int WIDE_KNOBS = 4;
	localparam int RANDOM_WORDS = 100;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ROW_COUNT = 22;
	localparam logic [mkrd_pkg::KNOB_W-1:0] NARROW_KNOB =
		mkrd_pkg::KNOB_W'(mkrd_pkg::NARROW_SLOT);

	typedef struct packed {
		logic [mkrd_pkg::KNOB_W-1:0] knob;
		logic                        ccw;
		logic                        last;
	} step_rep_t;

	typedef struct packed {
		mkrd_pkg::port_t             port;
		logic [mkrd_pkg::PIN_W-1:0]  pins;
		logic                        typed;
		logic [1:0]                  n_rep;
		logic [mkrd_pkg::KNOB_W-1:0] knob;
		logic                        ccw;
	} snap_row_t;

	localparam snap_row_t SNAP_ROWS [ROW_COUNT] = '{
		'{mkrd_pkg::PORT_WIDE,   8'hFD, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFE, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFF, 1'b1, 2'd1, 3'd0, 1'b1},
		'{mkrd_pkg::PORT_NARROW, 8'hFE, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_NARROW, 8'hFD, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_NARROW, 8'hFF, 1'b1, 2'd1, NARROW_KNOB, 1'b0},
		'{mkrd_pkg::PORT_NARROW, 8'h55, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_NARROW, 8'hAA, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_NARROW, 8'h03, 1'b1, 2'd1, NARROW_KNOB, 1'b1},
		'{mkrd_pkg::PORT_WIDE,   8'h55, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hAA, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFF, 1'b0, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hAA, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'h55, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFF, 1'b0, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'h00, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'h00, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'h00, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFF, 1'b0, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'h7F, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hBF, 1'b1, 2'd0, 3'd0, 1'b0},
		'{mkrd_pkg::PORT_WIDE,   8'hFF, 1'b1, 2'd1, 3'd3, 1'b1}
	};

	logic clk;
	logic arst_n;

	mkrd_in_if  sample_ch ();
	mkrd_out_if report_ch ();

	multi_knob_rotary_decoder_core #(
		.WIDE_PORT_KNOBS(WIDE_KNOBS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.report (report_ch)
	);

	logic [mkrd_pkg::PIN_W-1:0] held_snap [2][2];
	logic [1:0]                 held_fill [2];
	step_rep_t                  fresh_steps [$];
	step_rep_t                  due_steps [$];

	bit quiet_phase;
	int out_stall;
	int idle_cycles;
	int fail_count;
	int words_sent;
	int narrow_words;
	int steps_seen;
	int ccw_seen;
	int cw_seen;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// behavioral decoder: leaves this snapshot's reports in fresh_steps
	function automatic void decode_snapshot(mkrd_pkg::port_t port,
		logic [mkrd_pkg::PIN_W-1:0] pins);
		int p;
		int lanes;
		logic [mkrd_pkg::PIN_W-1:0] snap;
		logic [mkrd_pkg::PIN_W-1:0] old_s;
		logic [mkrd_pkg::PIN_W-1:0] oldest_s;
		step_rep_t rep;
		fresh_steps.delete();
		p = (port == mkrd_pkg::PORT_NARROW) ? 1 : 0;
		if (port == mkrd_pkg::PORT_NARROW)
			snap = {6'd0, ~pins[1:0] & mkrd_pkg::NARROW_MASK};
		else
			snap = ~pins & mkrd_pkg::WIDE_MASK;
		if (held_fill[p] < mkrd_pkg::FILL_FULL) begin
			held_snap[p][held_fill[p][0]] = snap;
			held_fill[p] = held_fill[p] + 2'd1;
			return;
		end
		old_s = held_snap[p][1];
		oldest_s = held_snap[p][0];
		lanes = (port == mkrd_pkg::PORT_NARROW) ? 1 : WIDE_KNOBS;
		for (int k = 0; k < lanes && k < mkrd_pkg::MAX_WIDE; k++) begin
			if (snap[2*k +: 2] == 2'b00) begin
				rep.knob = (port == mkrd_pkg::PORT_NARROW) ? NARROW_KNOB :
					mkrd_pkg::KNOB_W'(k);
				rep.last = 1'b0;
				if (old_s[2*k + mkrd_pkg::BIT_A] && oldest_s[2*k + mkrd_pkg::BIT_B]) begin
					rep.ccw = 1'b1;
					fresh_steps.push_back(rep);
				end else if (old_s[2*k + mkrd_pkg::BIT_B] &&
					oldest_s[2*k + mkrd_pkg::BIT_A]) begin
					rep.ccw = 1'b0;
					fresh_steps.push_back(rep);
				end
			end
		end
		if (fresh_steps.size() > 0) begin
			fresh_steps[fresh_steps.size() - 1].last = 1'b1;
			held_snap[p][0] = '0;
			held_snap[p][1] = '0;
			held_fill[p] = 2'd0;
		end else begin
			held_snap[p][0] = old_s;
			held_snap[p][1] = snap;
			held_fill[p] = mkrd_pkg::FILL_FULL;
		end
	endfunction

	task automatic send_word(input mkrd_pkg::port_t port,
		input logic [mkrd_pkg::PIN_W-1:0] pins, input logic typed,
		input logic [1:0] n_rep, input logic [mkrd_pkg::KNOB_W-1:0] knob, input logic ccw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.port_select <= port;
		sample_ch.pin_levels  <= pins;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		decode_snapshot(port, pins);
		if (typed) begin
			if (n_rep != 2'd0)
				due_steps.push_back('{knob, ccw, 1'b1});
		end else begin
			foreach (fresh_steps[i])
				due_steps.push_back(fresh_steps[i]);
		end
		words_sent++;
		if (port == mkrd_pkg::PORT_NARROW)
			narrow_words++;
	endtask

	// three snapshots shaped as a turn per knob, with random filler bits
	task automatic send_turns();
		mkrd_pkg::port_t port;
		logic [mkrd_pkg::PIN_W-1:0] s [3];
		logic [mkrd_pkg::PIN_W-1:0] pins;
		int lanes;
		int pick;
		port = mkrd_pkg::port_t'($urandom_range(0, 1));
		lanes = (port == mkrd_pkg::PORT_NARROW) ? 1 : WIDE_KNOBS;
		s[0] = '0;
		s[1] = '0;
		s[2] = '0;
		for (int k = 0; k < lanes; k++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				s[0][2*k + mkrd_pkg::BIT_B] = 1'b1;
				s[0][2*k + mkrd_pkg::BIT_A] = 1'($urandom_range(0, 1));
				s[1][2*k + mkrd_pkg::BIT_A] = 1'b1;
				s[1][2*k + mkrd_pkg::BIT_B] = 1'($urandom_range(0, 1));
			end else if (pick < 8) begin
				s[0][2*k + mkrd_pkg::BIT_A] = 1'b1;
				s[0][2*k + mkrd_pkg::BIT_B] = 1'($urandom_range(0, 1));
				s[1][2*k + mkrd_pkg::BIT_B] = 1'b1;
				s[1][2*k + mkrd_pkg::BIT_A] = 1'($urandom_range(0, 1));
			end else begin
				s[0][2*k +: 2] = 2'($urandom_range(0, 3));
				s[1][2*k +: 2] = 2'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 4) == 0)
				s[2][2*k +: 2] = 2'($urandom_range(0, 3));
		end
		for (int i = 0; i < 3; i++) begin
			pins = ~s[i];
			if (port == mkrd_pkg::PORT_NARROW)
				pins[7:2] = 6'($urandom_range(0, 63));
			send_word(port, pins, 1'b0, 2'd0, '0, 1'b0);
		end
	endtask

	// report side: check against the oldest due step, then pick ready
	initial report_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (report_ch.valid && report_ch.ready) begin
				steps_seen++;
				if (report_ch.counter_clockwise)
					ccw_seen++;
				else
					cw_seen++;
				if (due_steps.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected report: knob %0d ccw %0b last %0b",
							report_ch.knob_index, report_ch.counter_clockwise,
							report_ch.last_report);
				end else begin
					if (report_ch.knob_index !== due_steps[0].knob ||
						report_ch.counter_clockwise !== due_steps[0].ccw ||
						report_ch.last_report !== due_steps[0].last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp knob %0d ccw %0b last %0b, %s",
								due_steps[0].knob, due_steps[0].ccw, due_steps[0].last,
								$sformatf("got knob %0d ccw %0b last %0b",
								report_ch.knob_index, report_ch.counter_clockwise,
								report_ch.last_report));
					end
					void'(due_steps.pop_front());
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				report_ch.ready <= 1'b0;
			end else begin
				out_stall = pick_gap();
				report_ch.ready <= (out_stall == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d reports outstanding",
				IDLE_LIMIT, due_steps.size());
			$display("** multi_knob_rotary_decoder_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.port_select = mkrd_pkg::PORT_WIDE;
		sample_ch.pin_levels = '0;
		quiet_phase = 1'b0;
		out_stall = 0;
		idle_cycles = 0;
		fail_count = 0;
		words_sent = 0;
		narrow_words = 0;
		steps_seen = 0;
		ccw_seen = 0;
		cw_seen = 0;
		for (int p = 0; p < 2; p++) begin
			held_snap[p][0] = '0;
			held_snap[p][1] = '0;
			held_fill[p] = 2'd0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SNAP_ROWS[r])
			send_word(SNAP_ROWS[r].port, SNAP_ROWS[r].pins, SNAP_ROWS[r].typed,
				SNAP_ROWS[r].n_rep, SNAP_ROWS[r].knob, SNAP_ROWS[r].ccw);

		while (words_sent < ROW_COUNT + RANDOM_WORDS) begin
			if ((words_sent / 20) % 3 == 1)
				quiet_phase = 1'b1;
			else
				quiet_phase = 1'b0;
			if ($urandom_range(0, 4) == 0)
				send_word(mkrd_pkg::port_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'b0, 2'd0, '0, 1'b0);
			else
				send_turns();
		end
		sample_ch.valid <= 1'b0;
		quiet_phase = 1'b0;

		while (due_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d snapshots (%0d narrow), checked %0d reports", words_sent,
			narrow_words, steps_seen);
		$display("directions seen: %0d counter-clockwise, %0d clockwise, %0d failures",
			ccw_seen, cw_seen, fail_count);
		if (fail_count == 0)
			$display("** multi_knob_rotary_decoder_core: PASSED **");
		else
			$display("** multi_knob_rotary_decoder_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
